// ===== rtl/ffba_pkg.sv =====
// package for the first-fit block allocator
// types and constants shared by the control engine and its testbench
`default_nettype none
package ffba_pkg;
    localparam int unsigned SIZE_W   = 19;
    localparam int unsigned ADDR_W   = 18;
    localparam int unsigned LINK_W   = 7;
    localparam int unsigned STAT_W   = 3;
    localparam logic [LINK_W-1:0] NO_BLOCK = 7'd127;

    localparam logic [STAT_W-1:0] ST_ALLOC   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FREED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic              is_free;
        logic [LINK_W-1:0] next;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none
module ffba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// first-fit block allocator: block table in a ram, list walked one entry per step
// depends on ffba_pkg and ffba_ram
// walk: S_READ, then S_WAIT and S_EVAL for each entry visited, then S_WR2 (split) or S_NXRD and
//   S_NXEV (free merge), then S_OUT; zero-size or oversize allocs and null frees skip the walk
// one request at a time: s_axis_tready is high only when idle with no result pending, so the next
//   request can be taken the cycle after the result transfer
// reset: synchronous active low; the written bits clear and only slot 0 stays marked in use, so
//   the table reads as one free block covering the heap with no clearing pass
`default_nettype none
module first_fit_block_allocator #(
    parameter int unsigned HEAP_BYTES   = 262144,
    parameter int unsigned HEADER_BYTES = 24,
    parameter int unsigned MAX_BLOCKS   = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: req_size[18:0], free_addr[36:19], zero fill to 40
    input  wire logic [39:0] s_axis_tdata,
    // tuser: opcode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status[2:0], payload_addr[20:3], granted_size[39:21]
    output logic      [39:0] m_axis_tdata
);
    import ffba_pkg::*;

    localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [LINK_W-1:0] LAST_IDX = LINK_W'(MAX_BLOCKS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_WR2   = 3'd4;
    localparam logic [2:0] S_NXRD  = 3'd5;
    localparam logic [2:0] S_NXEV  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]            r_state, n_state;
    logic                  r_op;
    logic [SIZE_W-1:0]     r_need;
    logic [ADDR_W-1:0]     r_addr;
    logic [LINK_W-1:0]     r_cur;
    logic [LINK_W-1:0]     r_steps;
    t_entry                r_ent;
    logic [MAX_BLOCKS-1:0] r_used;
    logic [MAX_BLOCKS-1:0] r_wr;
    logic [STAT_W-1:0]     r_stat;
    logic [ADDR_W-1:0]     r_paddr;
    logic [SIZE_W-1:0]     r_gsize;
    logic                  r_ovalid;

    logic                  we;
    logic [IDX_W-1:0]      waddr, raddr;
    t_entry                wdata, rdata_raw, rdata;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot;
    logic [SIZE_W+1:0]     sum_w;

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    // entries never written read as their reset contents
    always_comb begin
        rdata = rdata_raw;
        if (!r_wr[r_rd_idx]) begin
            rdata.offset  = '0;
            rdata.size    = (r_rd_idx == '0) ? INIT_SIZE : '0;
            rdata.is_free = (r_rd_idx == '0);
            rdata.next    = NO_BLOCK;
        end
    end

    always_comb begin
        slot_ok = 1'b0;
        slot    = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                slot_ok = 1'b1;
                slot    = IDX_W'(i);
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_gsize, r_paddr, r_stat};
    assign sum_w = {2'b0, r_ent.size} + {2'b0, HDR} + {2'b0, rdata.size};

    wire in_fire = s_axis_tvalid && s_axis_tready;
    // zero-size or oversize alloc, or null free, answered without a walk
    wire in_short = (s_axis_tuser == OP_ALLOC) ?
        (s_axis_tdata[18:0] == '0 || {13'd0, s_axis_tdata[18:0]} > 32'(HEAP_BYTES)) :
        (s_axis_tdata[36:19] == '0);
    wire fit     = r_ent.is_free && (r_ent.size >= r_need);
    wire split   = (r_ent.size > r_need + HDR + SIZE_W'(8)) && slot_ok;
    wire hit     = ({1'b0, r_ent.offset} + {1'b0, HDR}) == {2'b0, r_addr};
    wire nx_ok   = r_ent.next <= LAST_IDX;

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        waddr   = r_cur[IDX_W-1:0];
        wdata   = r_ent;
        raddr   = r_cur[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && !in_short) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_WAIT;
            S_WAIT: n_state = S_EVAL;
            S_EVAL: begin
                if (r_op == OP_ALLOC && fit) begin
                    we = 1'b1;
                    wdata.is_free = 1'b0;
                    if (split) begin
                        wdata.next = LINK_W'(slot);
                        wdata.size = r_need;
                        n_state = S_WR2;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_op == OP_FREE && hit) begin
                    we = 1'b1;
                    wdata.is_free = 1'b1;
                    n_state = nx_ok ? S_NXRD : S_OUT;
                    raddr = r_ent.next[IDX_W-1:0];
                end else if (r_steps == LINK_W'(MAX_BLOCKS - 1) || !(r_ent.next <= LAST_IDX)) begin
                    n_state = S_OUT;
                end else begin
                    raddr = r_ent.next[IDX_W-1:0];
                    n_state = S_WAIT;
                end
            end
            S_WR2: begin
                we = 1'b1;
                waddr = slot;
                wdata.offset  = r_ent.offset + HDR + r_need;
                wdata.size    = r_ent.size - r_need - HDR;
                wdata.is_free = 1'b1;
                wdata.next    = r_ent.next;
                n_state = S_OUT;
            end
            S_NXRD: begin
                raddr = r_ent.next[IDX_W-1:0];
                n_state = S_NXEV;
            end
            S_NXEV: begin
                if (rdata.is_free) begin
                    we = 1'b1;
                    wdata.is_free = 1'b1;
                    wdata.size = sum_w[SIZE_W-1:0];
                    wdata.next = rdata.next;
                end
                n_state = S_OUT;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= MAX_BLOCKS'(1);
            r_wr     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) r_wr[waddr] <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op    <= s_axis_tuser;
                        r_addr  <= s_axis_tdata[36:19];
                        r_need  <= (s_axis_tdata[18:0] + SIZE_W'(7)) & ~SIZE_W'(7);
                        r_cur   <= '0;
                        r_steps <= '0;
                        r_paddr <= '0;
                        r_gsize <= '0;
                        r_rd_idx <= '0;
                        if (s_axis_tuser == OP_ALLOC) begin
                            r_stat <= ST_REFUSED;
                        end else if (s_axis_tdata[36:19] == '0) begin
                            r_stat <= ST_NULL;
                        end else begin
                            r_stat <= ST_UNKNOWN;
                        end
                        if (in_short) r_ovalid <= 1'b1;
                    end
                end
                S_WAIT: r_ent <= rdata;
                S_EVAL: begin
                    if (r_op == OP_ALLOC && fit) begin
                        r_stat  <= ST_ALLOC;
                        r_paddr <= ADDR_W'(r_ent.offset + HDR);
                        r_gsize <= split ? r_need : r_ent.size;
                    end else if (r_op == OP_FREE && hit) begin
                        r_stat <= ST_FREED;
                        r_ent.is_free <= 1'b1;
                        r_rd_idx <= r_ent.next[IDX_W-1:0];
                    end else begin
                        r_cur    <= r_ent.next;
                        r_steps  <= r_steps + 1'b1;
                        r_rd_idx <= r_ent.next[IDX_W-1:0];
                    end
                end
                S_WR2: r_used[slot] <= 1'b1;
                S_NXEV: if (rdata.is_free) r_used[r_ent.next[IDX_W-1:0]] <= 1'b0;
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_head_used: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_used[0])
        else $error("head slot released");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== bench/tb_first_fit_block_allocator.sv =====
// testbench for the first-fit block allocator: drives alloc and free requests
// depends on ffba_pkg and the allocator rtl; predicts each response from its own table copy
`default_nettype none
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int unsigned HEAP   = 262144;
    localparam int unsigned HDR    = 24;
    localparam int unsigned NBLK   = 64;
    localparam int unsigned ALIGN  = 8;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    first_fit_block_allocator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // shadow block table
    logic [SIZE_W-1:0] tbl_off  [NBLK];
    logic [SIZE_W-1:0] tbl_size [NBLK];
    logic              tbl_free [NBLK];
    logic [LINK_W-1:0] tbl_next [NBLK];
    logic              tbl_used [NBLK];

    t_resp             resp_q[$];
    logic [ADDR_W-1:0] live_q[$];
    int                err_cnt;
    bit                quiet;
    bit                calm;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic table_reset();
        for (int i = 0; i < NBLK; i++) begin
            tbl_off[i] = '0; tbl_size[i] = '0; tbl_free[i] = 1'b0;
            tbl_next[i] = NO_BLOCK; tbl_used[i] = 1'b0;
        end
        tbl_size[0] = SIZE_W'(HEAP - HDR);
        tbl_free[0] = 1'b1;
        tbl_used[0] = 1'b1;
    endtask

    function automatic t_resp predict_alloc(int unsigned req);
        t_resp r;
        int unsigned need, cur, slot;
        r = '{status: ST_REFUSED, addr: '0, size: '0};
        if (req == 0 || req > HEAP) return r;
        need = (req + ALIGN - 1) & ~(ALIGN - 1);
        cur = 0;
        for (int s = 0; s < NBLK && cur < NBLK; s++) begin
            if (tbl_free[cur] && tbl_size[cur] >= need) begin
                tbl_free[cur] = 1'b0;
                slot = NO_BLOCK;
                for (int i = NBLK - 1; i >= 0; i--) if (!tbl_used[i]) slot = i;
                if (tbl_size[cur] > need + HDR + ALIGN && slot < NBLK) begin
                    tbl_used[slot] = 1'b1;
                    tbl_free[slot] = 1'b1;
                    tbl_off[slot]  = SIZE_W'(tbl_off[cur] + HDR + need);
                    tbl_size[slot] = SIZE_W'(tbl_size[cur] - need - HDR);
                    tbl_next[slot] = tbl_next[cur];
                    tbl_next[cur]  = LINK_W'(slot);
                    tbl_size[cur]  = SIZE_W'(need);
                end
                r.status = ST_ALLOC;
                r.addr = ADDR_W'(tbl_off[cur] + HDR);
                r.size = tbl_size[cur];
                return r;
            end
            cur = tbl_next[cur];
        end
        return r;
    endfunction

    function automatic t_resp predict_free(logic [ADDR_W-1:0] a);
        t_resp r;
        int unsigned cur, nx;
        r = '{status: ST_UNKNOWN, addr: '0, size: '0};
        if (a == 0) begin
            r.status = ST_NULL;
            return r;
        end
        cur = 0;
        for (int s = 0; s < NBLK && cur < NBLK; s++) begin
            if (20'(tbl_off[cur]) + HDR == 20'(a)) begin
                tbl_free[cur] = 1'b1;
                nx = tbl_next[cur];
                if (nx < NBLK && tbl_free[nx]) begin
                    tbl_size[cur] = SIZE_W'(tbl_size[cur] + HDR + tbl_size[nx]);
                    tbl_next[cur] = tbl_next[nx];
                    tbl_used[nx] = 1'b0;
                    tbl_free[nx] = 1'b0;
                    tbl_next[nx] = NO_BLOCK;
                end
                r.status = ST_FREED;
                return r;
            end
            cur = tbl_next[cur];
        end
        return r;
    endfunction

    task automatic send_req(logic op, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] a);
        t_resp r;
        while (!quiet && !calm && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        r = (op == OP_ALLOC) ? predict_alloc(req) : predict_free(a);
        resp_q.push_back(r);
        if (op == OP_ALLOC && r.status == ST_ALLOC) live_q.push_back(r.addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b0, a, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
            if (m_axis_tvalid && m_axis_tready) begin
                if (resp_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    t_resp w, g;
                    w = resp_q.pop_front();
                    g = t_resp'({m_axis_tdata[2:0], m_axis_tdata[20:3], m_axis_tdata[39:21]});
                    if (g.status != w.status) report_mismatch("status", g.status, w.status);
                    if (g.addr != w.addr) report_mismatch("payload_addr", g.addr, w.addr);
                    if (g.size != w.size) report_mismatch("granted_size", g.size, w.size);
                end
            end
        end
    end

    function automatic logic [ADDR_W-1:0] pick_live();
        int k;
        logic [ADDR_W-1:0] a;
        k = $urandom_range(live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        return a;
    endfunction

    task automatic test_directed();
        send_req(OP_ALLOC, 19'd0, '0);
        send_req(OP_ALLOC, SIZE_W'(HEAP + 1), '0);
        send_req(OP_ALLOC, 19'h7FFFF, 18'h3FFFF);
        send_req(OP_ALLOC, SIZE_W'(HEAP), '0);
        send_req(OP_FREE, '0, '0);
        send_req(OP_FREE, 19'h7FFFF, 18'h3FFFF);
        send_req(OP_ALLOC, 19'd1, '0);
        send_req(OP_ALLOC, 19'd8, '0);
        send_req(OP_ALLOC, 19'd33, '0);
        send_req(OP_FREE, '0, 18'd24);
        send_req(OP_FREE, '0, 18'd24);
        send_req(OP_ALLOC, 19'd40, '0);
        send_req(OP_FREE, '0, 18'd56);
        send_req(OP_FREE, '0, 18'd57);
        send_req(OP_ALLOC, SIZE_W'(HEAP - HDR - 200), '0);
        send_req(OP_ALLOC, SIZE_W'(HEAP - HDR), '0);
        send_req(OP_FREE, '0, 18'd24);
        send_req(OP_FREE, '0, 18'd48);
        while (live_q.size() > 0) send_req(OP_FREE, '0, pick_live());
        send_req(OP_FREE, '0, 18'd24);
    endtask

    task automatic test_table_full();
        // fill every slot so later allocs take whole blocks without a split
        for (int i = 0; i < 70; i++) send_req(OP_ALLOC, SIZE_W'($urandom_range(1, 64)), '0);
        send_req(OP_ALLOC, 19'd8, '0);
        while (live_q.size() > 0) send_req(OP_FREE, '0, pick_live());
    endtask

    task automatic test_random(int n);
        int unsigned k;
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 3 && i < n / 3 + 200);
            k = $urandom_range(99);
            if (k < 45) begin
                case ($urandom_range(3))
                    0: sz = SIZE_W'($urandom_range(1, 64));
                    1: sz = SIZE_W'($urandom_range(1, 4096));
                    2: sz = SIZE_W'($urandom_range(1, 40000));
                    default: sz = SIZE_W'($urandom);
                endcase
                send_req(OP_ALLOC, sz, ADDR_W'($urandom));
            end else if (k < 85 && live_q.size() > 0) begin
                send_req(OP_FREE, SIZE_W'($urandom), pick_live());
            end else if (k < 92) begin
                send_req(OP_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
            end else if (k < 96) begin
                send_req(OP_FREE, SIZE_W'($urandom), '0);
            end else begin
                send_req(OP_ALLOC, $urandom_range(1) ? 19'd0 :
                         19'($urandom_range(HEAP + 1, 19'h7FFFF)), ADDR_W'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        err_cnt = 0;
        quiet = 1'b0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        table_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(1800);
        s_axis_tvalid <= 1'b0;
        while (resp_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (err_cnt == 0 && resp_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/first_fit_block_allocator.sv
bench/tb_first_fit_block_allocator.sv
